/* rtl/core/sm3_pkg.sv */
// Package for the SM3 hash engine: initial value, round constants and helpers.
// No dependencies.
`timescale 1ns / 1ps
package sm3_pkg;
	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t      data;
		logic       pad;
		logic       len;
	} fifo_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LENHI,
		ST_LENLO,
		ST_EMIT
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_FOLD
	} back_state_t;

	localparam word_t T_LOW  = 32'h79CC4519;
	localparam word_t T_HIGH = 32'h7A879D8A;
	localparam word_t PAD_WORD = 32'h80000000;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 32'h7380166F;
			3'd1: r = 32'h4914B2B9;
			3'd2: r = 32'h172442D7;
			3'd3: r = 32'hDA8A0600;
			3'd4: r = 32'hA96F30BC;
			3'd5: r = 32'h163138AA;
			3'd6: r = 32'hE38DEE4D;
			default: r = 32'hB0FB0E4E;
		endcase
		return r;
	endfunction

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic word_t p0(input word_t x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic word_t p1(input word_t x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction
endpackage

/* rtl/core/sm3_front.sv */
// Front end: takes message beats, counts length, inserts padding and length words.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
module sm3_front import sm3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  word_t      message_word,
	input  logic [2:0] valid_bytes,
	input  logic       final_req,
	output logic       fq_push,
	input  logic       fq_full,
	output word_t      fq_data,
	output logic       fq_last
);
	front_state_t state_q, state_d;
	logic [63:0] len_q;
	logic [3:0]  fill_q;
	logic [2:0]  vb;
	word_t       keep, last_w;
	logic        acc;
	logic [63:0] len_d;
	// The first padding beat after a full final word carries the marker byte.
	logic        pad_first_q;

	always_comb begin
		vb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
		keep = (vb == 3'd0) ? 32'h0 : (32'hFFFFFFFF << {(3'd4 - vb), 3'b000});
		last_w = (message_word & keep) | ({24'h0, PAD_BYTE} << {2'd3 - vb[1:0], 3'b000});
	end

	always_comb begin
		state_d = state_q;
		full = 1'b1;
		fq_push = 1'b0;
		fq_data = message_word;
		fq_last = 1'b0;
		acc = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				full = fq_full;
				acc = push && !fq_full;
				fq_push = acc;
				if (final_req && vb != 3'd4) begin
					fq_data = last_w;
				end
				if (acc && final_req) begin
					if (vb == 3'd4) begin
						state_d = ST_PAD;
					end else if (fill_q == 4'd13) begin
						state_d = ST_LENHI;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				fq_push = !fq_full;
				fq_data = pad_first_q ? PAD_WORD : 32'h0;
				if (!fq_full && fill_q == 4'd13) begin
					state_d = ST_LENHI;
				end
			end
			ST_LENHI: begin
				fq_push = !fq_full;
				fq_data = len_q[63:32];
				if (!fq_full) begin
					state_d = ST_LENLO;
				end
			end
			ST_LENLO: begin
				fq_push = !fq_full;
				fq_data = len_q[31:0];
				fq_last = 1'b1;
				if (!fq_full) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		len_d = len_q + (final_req ? {58'h0, vb, 3'b000} : 64'd32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			fill_q <= '0;
			pad_first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				len_q <= len_d;
				pad_first_q <= final_req && vb == 3'd4;
			end
			if (fq_push) begin
				if (fq_last) begin
					fill_q <= '0;
					len_q <= '0;
				end else begin
					fill_q <= fill_q + 4'd1;
				end
				if (state_q == ST_PAD) begin
					pad_first_q <= 1'b0;
				end
			end
		end
	end
endmodule

/* rtl/core/sm3_fifo.sv */
// Short queue between the front end and the compression core.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
module sm3_fifo import sm3_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	output logic  wr_full,
	input  word_t wr_data,
	input  logic  wr_last,
	input  logic  wr_pad,
	output logic  rd_valid,
	input  logic  rd,
	output fifo_item_t rd_item
);
	fifo_item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign wr_full = (cnt_q == 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !wr_full) begin
			mem_q[wp_q] <= '{data: wr_data, pad: wr_pad, len: wr_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !wr_full) wp_q <= wp_q + 2'd1;
			if (rd && rd_valid) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr && !wr_full} - {2'b0, rd && rd_valid};
		end
	end
endmodule

/* rtl/core/sm3_core.sv */
// Compression core: block buffer, message expansion window, 64 rounds, digest queue.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
module sm3_core import sm3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_take,
	input  fifo_item_t in_item,
	output logic       empty,
	input  logic       pop,
	output word_t      digest_word,
	output logic [2:0] word_index,
	output logic       last_word
);
	back_state_t st_q;
	word_t blk_q [16];
	word_t cv_q [8];
	word_t wr_q [8];
	logic [3:0] fill_q;
	logic [5:0] rnd_q;
	logic fin_q;
	logic out_q;
	logic [2:0] idx_q;
	word_t dg_q [8];

	word_t wj, wj4, wn, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
	logic hi;

	always_comb begin
		hi = rnd_q[5] | rnd_q[4];
		tj = hi ? T_HIGH : T_LOW;
		wj = blk_q[0];
		wj4 = blk_q[4];
		wn = p1(blk_q[0] ^ blk_q[7] ^ rotl(blk_q[13], 5'd15)) ^ rotl(blk_q[3], 5'd7)
			^ blk_q[10];
		a12 = rotl(wr_q[0], 5'd12);
		ss1 = rotl(a12 + wr_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		ff = hi ? ((wr_q[0] & wr_q[1]) | (wr_q[0] & wr_q[2]) | (wr_q[1] & wr_q[2]))
			: (wr_q[0] ^ wr_q[1] ^ wr_q[2]);
		gg = hi ? ((wr_q[4] & wr_q[5]) | (~wr_q[4] & wr_q[6]))
			: (wr_q[4] ^ wr_q[5] ^ wr_q[6]);
		tt1 = ff + wr_q[3] + ss2 + (wj ^ wj4);
		tt2 = gg + wr_q[7] + ss1 + wj;
	end

	assign in_take = (st_q == BK_IDLE) && !out_q && in_valid;
	assign empty = !out_q;
	assign digest_word = dg_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (in_take) begin
			blk_q[fill_q] <= in_item.data;
		end
		if (st_q == BK_IDLE && in_take && fill_q == 4'd15) begin
			for (int i = 0; i < 8; i++) wr_q[i] <= cv_q[i];
		end
		if (st_q == BK_RUN) begin
			for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i + 1];
			blk_q[15] <= wn;
			wr_q[0] <= tt1;
			wr_q[1] <= wr_q[0];
			wr_q[2] <= rotl(wr_q[1], 5'd9);
			wr_q[3] <= wr_q[2];
			wr_q[4] <= p0(tt2);
			wr_q[5] <= wr_q[4];
			wr_q[6] <= rotl(wr_q[5], 5'd19);
			wr_q[7] <= wr_q[6];
		end
		if (st_q == BK_FOLD && fin_q) begin
			for (int i = 0; i < 8; i++) dg_q[i] <= cv_q[i] ^ wr_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			fill_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			out_q <= 1'b0;
			idx_q <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
		end else begin
			unique case (st_q)
				BK_IDLE: begin
					if (in_take) begin
						fill_q <= fill_q + 4'd1;
						if (fill_q == 4'd15) begin
							st_q <= BK_RUN;
							rnd_q <= '0;
							fin_q <= in_item.len;
						end
					end
				end
				BK_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) st_q <= BK_FOLD;
				end
				default: begin
					st_q <= BK_IDLE;
					if (fin_q) begin
						for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
						out_q <= 1'b1;
						idx_q <= '0;
					end else begin
						for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ wr_q[i];
					end
				end
			endcase
			if (out_q && pop) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) out_q <= 1'b0;
			end
		end
	end
endmodule

/* rtl/core/sm3_hash_engine.sv */
// Top level of the SM3 hash engine: front end, beat queue and compression core.
// Depends on sm3_pkg, sm3_front, sm3_fifo and sm3_core.
//
// channel   | handshake      | payload
// message   | push / full    | message_word, valid_bytes, final_req
// digest    | pop / empty    | digest_word, word_index, last_word
//
// A block of 16 words costs 16 queue beats, 64 rounds in the single round unit and
// one fold; the core takes no new queue beat until the fold is done.
// Padding adds up to 18 beats and one more block. No clearing pass after reset.
// The eight digest beats must be popped before the next block is compressed.
`timescale 1ns / 1ps
module sm3_hash_engine import sm3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [31:0] message_word,
	input  logic [2:0] valid_bytes,
	input  logic       final_req,
	output logic       empty,
	input  logic       pop,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic       last_word
);
	logic fq_push, fq_full, fq_last, rd_valid, rd_take;
	word_t fq_data;
	fifo_item_t rd_item;

	sm3_front u_front (
		.clk, .arst_n, .push, .full, .message_word, .valid_bytes, .final_req,
		.fq_push, .fq_full, .fq_data, .fq_last
	);

	sm3_fifo u_fifo (
		.clk, .arst_n, .wr(fq_push), .wr_full(fq_full), .wr_data(fq_data),
		.wr_last(fq_last), .wr_pad(1'b0), .rd_valid, .rd(rd_take), .rd_item
	);

	sm3_core u_core (
		.clk, .arst_n, .in_valid(rd_valid), .in_take(rd_take), .in_item(rd_item),
		.empty, .pop, .digest_word, .word_index, .last_word
	);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_word == (word_index == 3'd7)))
		else $error("last_word does not match index");
	a_no_take_out: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !rd_take)
		else $error("core took a beat while the digest was pending");
endmodule

/* tb/sm3_checker.sv */
// Checker for the SM3 hash engine: watches the message and digest channels,
// predicts digests from accepted message beats and compares each digest beat.
// Depends on sm3_pkg for the word type and the initial value.
`timescale 1ns / 1ps
module sm3_checker import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        final_req,
	input  logic        empty,
	input  logic        pop,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_count,
	output int          digest_count
);
	typedef struct {
		word_t      data;
		logic [2:0] idx;
		logic       last;
	} digest_beat_t;

	word_t        chain[8];
	word_t        blk[16];
	int unsigned  fill;
	logic [63:0]  msg_bits;
	digest_beat_t digest_q[$];

	function automatic word_t rol(word_t x, int n);
		n = n % 32;
		if (n == 0)
			return x;
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic compress();
		word_t w[68];
		word_t r[8];
		word_t a12, ss1, ss2, ff, gg, tt1, tt2, tj;
		for (int j = 0; j < 16; j++)
			w[j] = blk[j];
		for (int j = 16; j < 68; j++) begin
			tt1 = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
			w[j] = tt1 ^ rol(tt1, 15) ^ rol(tt1, 23) ^ rol(w[j-13], 7) ^ w[j-6];
		end
		for (int j = 0; j < 8; j++)
			r[j] = chain[j];
		for (int j = 0; j < 64; j++) begin
			tj = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
			a12 = rol(r[0], 12);
			ss1 = rol(a12 + r[4] + rol(tj, j), 7);
			ss2 = ss1 ^ a12;
			ff = (j < 16) ? (r[0] ^ r[1] ^ r[2]) : ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
			gg = (j < 16) ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
			tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + r[7] + ss1 + w[j];
			r[3] = r[2];
			r[2] = rol(r[1], 9);
			r[1] = r[0];
			r[0] = tt1;
			r[7] = r[6];
			r[6] = rol(r[5], 19);
			r[5] = r[4];
			r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
		end
		for (int j = 0; j < 8; j++)
			chain[j] ^= r[j];
	endtask

	task automatic absorb(word_t x);
		blk[fill] = x;
		fill++;
		if (fill == 16) begin
			fill = 0;
			compress();
		end
	endtask

	task automatic restart();
		for (int k = 0; k < 8; k++)
			chain[k] = iv_word(3'(k));
		fill = 0;
		msg_bits = '0;
	endtask

	task automatic take_message(word_t x, logic [2:0] nb, logic fin);
		int vb;
		word_t keep;
		digest_beat_t b;
		if (!fin) begin
			msg_bits += 64'd32;
			absorb(x);
			return;
		end
		vb = (nb > 3'd4) ? 4 : int'(nb);
		msg_bits += 64'(8 * vb);
		if (vb == 4) begin
			absorb(x);
			absorb(32'h80000000);
		end else begin
			keep = (vb == 0) ? '0 : (32'hFFFFFFFF << (8 * (4 - vb)));
			absorb((x & keep) | (32'h80 << (8 * (3 - vb))));
		end
		while (fill != 14)
			absorb('0);
		absorb(msg_bits[63:32]);
		absorb(msg_bits[31:0]);
		for (int k = 0; k < 8; k++) begin
			b.data = chain[k];
			b.idx = 3'(k);
			b.last = (k == 7);
			digest_q.push_back(b);
		end
		restart();
	endtask

	initial begin
		fail_count = 0;
		digest_count = 0;
		pending_count = 0;
		restart();
	end

	always @(posedge clk) begin
		digest_beat_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					$display("%0t: digest beat with none expected: got %h idx %0d last %0b",
						$time, digest_word, word_index, last_word);
					fail_count++;
				end else begin
					e = digest_q.pop_front();
					digest_count++;
					if (digest_word !== e.data || word_index !== e.idx || last_word !== e.last) begin
						$display("%0t: digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
							$time, e.data, e.idx, e.last, digest_word, word_index, last_word);
						fail_count++;
					end
				end
			end
			if (push && !full)
				take_message(message_word, valid_bytes, final_req);
			pending_count = digest_q.size();
		end
	end
endmodule

/* tb/tb.sv */
// Testbench top for the SM3 hash engine: drives message beats with random gaps,
// pops digest beats with random stalls and reports the verdict.
// Depends on sm3_pkg, sm3_hash_engine and sm3_checker.
`timescale 1ns / 1ps
module tb;
	import sm3_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	logic [31:0] message_word = '0;
	logic [2:0]  valid_bytes = '0;
	logic        final_req = 0;
	logic        empty;
	logic        pop = 0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count, pending_count, digest_count;
	int          cycles = 0;
	int          messages = 0;
	bit          calm = 0;
	bit          feeding = 1;

	localparam int CYCLE_LIMIT = 400000;

	always #2 clk = ~clk;

	sm3_hash_engine dut (.*);

	sm3_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Digest side: bursts of stall, none once the run goes calm.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 7);
				pop <= 0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1;
		end
	end

	task automatic send(word_t w, logic [2:0] nb, logic fin);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		message_word <= w;
		valid_bytes <= nb;
		final_req <= fin;
		do @(posedge clk); while (full);
		if (fin)
			messages++;
	endtask

	task automatic send_message(int nwords, logic [2:0] nb);
		for (int i = 0; i < nwords; i++)
			send($urandom(), 3'($urandom_range(0, 7)), 0);
		send($urandom(), nb, 1);
	endtask

	// Dropping push and waiting for the clock first lets the checker count the last accepted beat.
	task automatic drain();
		push <= 0;
		@(posedge clk);
		wait (pending_count == 0);
	endtask

	initial begin
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: empty message, each byte count, oversized counts, extreme words,
		// padding that spills into an extra block.
		send(32'hFFFFFFFF, 3'd0, 1);
		send(32'h61626300, 3'd3, 1);
		send(32'hFFFFFFFF, 3'd4, 1);
		send(32'hFFFFFFFF, 3'd7, 1);
		send(32'h00000000, 3'd5, 1);
		send(32'hFFFFFFFF, 3'd1, 1);
		send(32'hFFFFFFFF, 3'd2, 1);
		for (int i = 0; i < 13; i++)
			send(32'hFFFFFFFF, 3'd7, 0);
		send(32'h12345678, 3'd4, 1);
		drain();
		// Random messages, mostly short, a few spanning several blocks.
		n = 0;
		while (n < 400) begin
			int len;
			if (n > 340)
				calm = 1;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 15);
			send_message(len, 3'($urandom_range(0, 7)));
			n += len + 1;
			if (n > 150 && n < 170)
				drain();
		end
		drain();
		repeat (200) @(posedge clk);
		$display("Ran %0d messages of 0 to 40 words with random gaps and stalls;", messages);
		$display("%0d digest beats checked, including empty and padding-overflow cases.",
			digest_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/core/sm3_pkg.sv
rtl/core/sm3_front.sv
rtl/core/sm3_fifo.sv
rtl/core/sm3_core.sv
rtl/core/sm3_hash_engine.sv
tb/sm3_checker.sv
tb/tb.sv
